@@ rtl/core/urpi_pkg.sv @@
// Shared types, constants and the range band table of the proximity indicator.
`default_nettype none
package urpi_pkg;

  localparam int DEFAULT_COUNT_BITS = 16;

  // Echo ticks are scaled by 125/232 to give centimetres.
  localparam int CM_NUMER = 125;
  localparam int CM_DENOM = 232;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_ADDR_W-1:0] CFG_TICKS_PER_MS    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_TRIGGER_HIGH_MS = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_TRIGGER_LOW_MS  = 2'd2;

  localparam logic [7:0] RST_TICKS_PER_MS    = 8'd32;
  localparam logic [7:0] RST_TRIGGER_HIGH_MS = 8'd1;
  localparam logic [9:0] RST_TRIGGER_LOW_MS  = 10'd60;

  localparam logic [2:0] LED_RED   = 3'b001;
  localparam logic [2:0] LED_GREEN = 3'b010;
  localparam logic [2:0] LED_BLUE  = 3'b100;

  localparam logic [15:0] STEADY_RED_CM = 16'd10;
  localparam logic [15:0] GREEN_CM      = 16'd200;
  localparam logic [15:0] BLUE_CM       = 16'd100;
  localparam logic [31:0] DIST_SAT      = 32'd65535;

  typedef struct packed {
    logic [7:0] ticks_per_ms;
    logic [7:0] trigger_high_ms;
    logic [9:0] trigger_low_ms;
  } cfg_t;

  // One classified tick handed from the front end to the blinker.
  typedef struct packed {
    logic        ms_tick;
    logic        trigger;
    logic        done;
    logic [15:0] distance;
    logic [10:0] period;
  } tick_rec_t;

  function automatic logic [10:0] band_period(input logic [31:0] d);
    logic [10:0] p;
    if (d >= 32'd200)      p = 11'd2000;
    else if (d >= 32'd180) p = 11'd1000;
    else if (d >= 32'd160) p = 11'd800;
    else if (d >= 32'd140) p = 11'd600;
    else if (d >= 32'd120) p = 11'd400;
    else if (d >= 32'd100) p = 11'd200;
    else if (d >= 32'd75)  p = 11'd1000;
    else if (d >= 32'd50)  p = 11'd800;
    else if (d >= 32'd25)  p = 11'd600;
    else                   p = 11'd400;
    return p;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/urpi_front.sv @@
// Front end: millisecond prescaler, trigger sequencer and echo pulse timing.
`default_nettype none
module urpi_front import urpi_pkg::*; #(
  parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cfg_t      cfg,
  input  wire logic      item_valid,
  input  wire logic      echo,
  input  wire logic      q_full,
  output logic           item_ready,
  output logic           q_wr,
  output tick_rec_t      q_wdata
);

  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};
  localparam logic [8:0] Numer = 9'(CM_NUMER);
  localparam logic [8:0] Denom = 9'(CM_DENOM);

  logic [7:0]            sub_r, sub_nxt;
  logic [9:0]            trig_cnt_r, trig_cnt_nxt;
  logic                  phase_r, phase_nxt;
  logic                  prev_r;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  // Running quotient and remainder of cnt*125/232, advanced per tick.
  logic [COUNT_BITS-1:0] quo_r, quo_nxt;
  logic [7:0]            rem_r, rem_nxt;

  logic       accept;
  logic       ms_tick;
  logic       falling;
  logic [8:0] rem_sum;
  logic [9:0] phase_len;

  assign item_ready = !q_full;
  assign accept     = item_valid && item_ready;
  assign q_wr       = accept;

  always_comb begin
    sub_nxt = sub_r + 8'd1;
    ms_tick = 1'b0;
    if (sub_nxt >= cfg.ticks_per_ms) begin
      sub_nxt = '0;
      ms_tick = 1'b1;
    end

    trig_cnt_nxt = trig_cnt_r;
    phase_nxt    = phase_r;
    phase_len    = phase_r ? {2'b00, cfg.trigger_high_ms} : cfg.trigger_low_ms;
    if (ms_tick) begin
      trig_cnt_nxt = trig_cnt_r + 10'd1;
      if (trig_cnt_nxt >= phase_len) begin
        phase_nxt    = !phase_r;
        trig_cnt_nxt = '0;
      end
    end

    cnt_nxt = cnt_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    rem_sum = {1'b0, rem_r} + Numer;
    if (echo && !prev_r) begin
      cnt_nxt = '0;
      quo_nxt = '0;
      rem_nxt = '0;
    end else if (prev_r && cnt_r != CountMax) begin
      cnt_nxt = cnt_r + 1'b1;
      if (rem_sum >= Denom) begin
        rem_nxt = 8'(rem_sum - Denom);
        quo_nxt = quo_r + 1'b1;
      end else begin
        rem_nxt = rem_sum[7:0];
      end
    end
    falling = !echo && prev_r;

    q_wdata.ms_tick  = ms_tick;
    q_wdata.trigger  = phase_nxt;
    q_wdata.done     = falling;
    q_wdata.distance = (32'(quo_nxt) > DIST_SAT) ? 16'hFFFF : 16'(quo_nxt);
    q_wdata.period   = band_period(32'(quo_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r      <= '0;
      trig_cnt_r <= '0;
      phase_r    <= 1'b1;
      prev_r     <= 1'b0;
      cnt_r      <= '0;
      quo_r      <= '0;
      rem_r      <= '0;
    end else if (accept) begin
      sub_r      <= sub_nxt;
      trig_cnt_r <= trig_cnt_nxt;
      phase_r    <= phase_nxt;
      prev_r     <= echo;
      cnt_r      <= cnt_nxt;
      quo_r      <= quo_nxt;
      rem_r      <= rem_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/urpi_fifo.sv @@
// Short queue of classified ticks between the front end and the blinker.
`default_nettype none
module urpi_fifo import urpi_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      wr,
  input  wire tick_rec_t wdata,
  input  wire logic      rd,
  output logic           full,
  output logic           not_empty,
  output tick_rec_t      rdata
);

  tick_rec_t         mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rdata     = mem[rptr_r];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (wr) wptr_r <= ptr_inc(wptr_r);
      if (rd) rptr_r <= ptr_inc(rptr_r);
      if (wr && !rd)      cnt_r <= cnt_r + 1'b1;
      else if (rd && !wr) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/urpi_back.sv @@
// Back end: measurement registers, blink timer, LED state and the output register.
`default_nettype none
module urpi_back import urpi_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      q_valid,
  input  wire tick_rec_t q_rdata,
  output logic           q_rd,
  output logic           out_tvalid,
  input  wire logic      out_tready,
  output logic [31:0]    out_tdata
);

  logic [15:0] dist_r, dist_nxt;
  logic [10:0] period_r, period_nxt;
  logic [10:0] wait_r, wait_nxt;
  logic        waiting_r, waiting_nxt;
  logic [2:0]  led_r, led_nxt;
  logic        valid_r;
  logic [31:0] data_r;
  logic [2:0]  on_colour;

  assign q_rd       = q_valid && (!valid_r || out_tready);
  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

  always_comb begin
    dist_nxt    = dist_r;
    period_nxt  = period_r;
    wait_nxt    = wait_r;
    waiting_nxt = waiting_r;
    led_nxt     = led_r;
    on_colour   = LED_RED;

    if (q_rdata.done) begin
      dist_nxt = q_rdata.distance;
      if (q_rdata.period != period_r) waiting_nxt = 1'b0;
      period_nxt = q_rdata.period;
    end

    if (waiting_nxt && q_rdata.ms_tick) begin
      wait_nxt = wait_r + 11'd1;
      if (wait_nxt >= period_nxt) waiting_nxt = 1'b0;
    end

    if (!waiting_nxt) begin
      if (dist_nxt < STEADY_RED_CM) begin
        led_nxt = LED_RED;
      end else begin
        if (dist_nxt >= GREEN_CM)     on_colour = LED_GREEN;
        else if (dist_nxt >= BLUE_CM) on_colour = LED_BLUE;
        else                          on_colour = LED_RED;
        led_nxt = (led_r & on_colour) ^ on_colour;
        // A zero period never starts a wait, so the colour toggles every tick.
        if (period_nxt != '0) begin
          waiting_nxt = 1'b1;
          wait_nxt    = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r    <= '0;
      period_r  <= '0;
      wait_r    <= '0;
      waiting_r <= 1'b0;
      led_r     <= '0;
      valid_r   <= 1'b0;
    end else begin
      if (q_rd) begin
        dist_r    <= dist_nxt;
        period_r  <= period_nxt;
        wait_r    <= wait_nxt;
        waiting_r <= waiting_nxt;
        led_r     <= led_nxt;
        valid_r   <= 1'b1;
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      data_r <= {period_nxt, q_rdata.done, dist_nxt,
                 led_nxt[2], led_nxt[1], led_nxt[0], q_rdata.trigger};
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/ultrasonic_range_proximity_indicator_core.sv @@
// Top level of the ultrasonic range proximity indicator.
//
//  channel | direction | contents
//  --------+-----------+---------------------------------------------------
//  in_     | slave     | one counter tick: the sampled echo level
//  out_    | master    | one status word per tick: trigger, LEDs, range
//  cfg_    | write     | ticks_per_ms, trigger_high_ms, trigger_low_ms
//
// A new transfer is taken each cycle while the two-entry queue has room. The
// front end writes each tick into the queue on its input transfer; the blinker
// reads it from the queue and loads the output register, which drives the
// output transfer. Reset is synchronous. A stalled output holds its word and
// backs up the queue, which then deasserts in_tready.
`default_nettype none
module ultrasonic_range_proximity_indicator_core import urpi_pkg::*; #(
  parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [7:0]            in_tdata,   // [0] echo_level, [7:1] zero
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [0] trigger_out, [1] led_red, [2] led_green, [3] led_blue,
  // [19:4] distance_cm, [20] measure_done, [31:21] blink_period_ms
  output logic [31:0]                out_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t      cfg_r;
  logic      q_full, q_not_empty, q_wr, q_rd;
  tick_rec_t q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ticks_per_ms    <= RST_TICKS_PER_MS;
      cfg_r.trigger_high_ms <= RST_TRIGGER_HIGH_MS;
      cfg_r.trigger_low_ms  <= RST_TRIGGER_LOW_MS;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_TICKS_PER_MS:    cfg_r.ticks_per_ms    <= cfg_wdata[7:0];
        CFG_TRIGGER_HIGH_MS: cfg_r.trigger_high_ms <= cfg_wdata[7:0];
        CFG_TRIGGER_LOW_MS:  cfg_r.trigger_low_ms  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  urpi_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (in_tvalid),
    .echo       (in_tdata[0]),
    .q_full     (q_full),
    .item_ready (in_tready),
    .q_wr       (q_wr),
    .q_wdata    (q_wdata)
  );

  urpi_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (q_wr),
    .wdata     (q_wdata),
    .rd        (q_rd),
    .full      (q_full),
    .not_empty (q_not_empty),
    .rdata     (q_rdata)
  );

  urpi_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_not_empty),
    .q_rdata    (q_rdata),
    .q_rd       (q_rd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire
